[rtl/csr_sparse_matvec_defines.svh]
// Assertion macros shared by the sparse matrix-vector RTL.
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT_IMPLY(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("csr_sparse_matvec: same-cycle check failed");
`define CSM_ASSERT_NEXT(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("csr_sparse_matvec: next-cycle check failed");
`else
`define CSM_ASSERT_IMPLY(label, ck, rn, pre, post)
`define CSM_ASSERT_NEXT(label, ck, rn, pre, post)
`endif
`endif

[rtl/csm_pkg.sv]
// Shared types and fixed field widths of the sparse matrix-vector block.
`default_nettype none
package csm_pkg;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int FIELD_W = 16;
  localparam int ACC_W   = 48;
  localparam int ROW_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_END_ROW = 2'd2
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } item_ctl_t;
endpackage
`default_nettype wire

[rtl/csm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

[rtl/csm_front.sv]
// Input register, index reduction, component extraction and vector store access.
`default_nettype none
module csm_front import csm_pkg::*; #(
  parameter int VEC_DEPTH  = 1024,
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic [CMD_W-1:0]             in_command,
  input  logic [IDX_W-1:0]             in_index,
  input  logic signed [FIELD_W-1:0]    in_value_re,
  input  logic signed [FIELD_W-1:0]    in_value_im,
  output item_ctl_t                    ctl_out,
  output logic signed [COMP_WIDTH-1:0] a_re,
  output logic signed [COMP_WIDTH-1:0] a_im,
  output logic signed [COMP_WIDTH-1:0] b_re,
  output logic signed [COMP_WIDTH-1:0] b_im
);
  localparam int ADDR_W = $clog2(VEC_DEPTH);
  localparam int EXT_W  = (COMP_WIDTH > FIELD_W) ? COMP_WIDTH : FIELD_W;

  logic [ADDR_W-1:0]            addr;
  logic [EXT_W-1:0]             ext_re;
  logic [EXT_W-1:0]             ext_im;
  logic signed [COMP_WIDTH-1:0] comp_re;
  logic signed [COMP_WIDTH-1:0] comp_im;
  item_ctl_t                    dec_ctl;

  item_ctl_t                    ctl_s1_r;
  logic [ADDR_W-1:0]            addr_s1_r;
  logic signed [COMP_WIDTH-1:0] a_re_s1_r;
  logic signed [COMP_WIDTH-1:0] a_im_s1_r;
  item_ctl_t                    ctl_s2_r;
  logic signed [COMP_WIDTH-1:0] a_re_s2_r;
  logic signed [COMP_WIDTH-1:0] a_im_s2_r;

  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [2*COMP_WIDTH-1:0]      ram_rd_data;

  // reduce the column index modulo the store depth
  generate
    if (VEC_DEPTH >= (1 << IDX_W)) begin : g_idx_direct
      assign addr = ADDR_W'(in_index);
    end else begin : g_idx_reduce
      localparam int RECIP_SH = 2 * IDX_W;
      localparam int RECIP    = (1 << RECIP_SH) / VEC_DEPTH;
      localparam int SCALED_W = IDX_W + RECIP_SH;

      logic [SCALED_W-1:0]  scaled;
      logic [IDX_W-1:0]     quot;
      logic [2*IDX_W-1:0]   back;
      logic [IDX_W-1:0]     rem0;

      // quotient estimate is exact or one low, so one correction step suffices
      assign scaled = SCALED_W'(in_index) * SCALED_W'(RECIP);
      assign quot   = scaled[SCALED_W-1:RECIP_SH];
      assign back   = (2*IDX_W)'(quot) * (2*IDX_W)'(VEC_DEPTH);
      assign rem0   = in_index - back[IDX_W-1:0];
      assign addr   = (rem0 >= IDX_W'(VEC_DEPTH)) ? ADDR_W'(rem0 - IDX_W'(VEC_DEPTH))
                                                  : ADDR_W'(rem0);
    end
  endgenerate

  // take the low component bits; a field narrower than the component is not sign-extended
  assign ext_re  = EXT_W'($unsigned(in_value_re));
  assign ext_im  = EXT_W'($unsigned(in_value_im));
  assign comp_re = $signed(ext_re[COMP_WIDTH-1:0]);
  assign comp_im = $signed(ext_im[COMP_WIDTH-1:0]);

  always_comb begin
    dec_ctl.valid = in_valid;
    dec_ctl.cmd   = CMD_LOAD;
    case (in_command)
      CMD_LOAD:    dec_ctl.cmd = CMD_LOAD;
      CMD_NONZERO: dec_ctl.cmd = CMD_NONZERO;
      CMD_END_ROW: dec_ctl.cmd = CMD_END_ROW;
      default:     dec_ctl.valid = 1'b0;  // drop the unused code
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r <= '0;
      ctl_s2_r <= '0;
    end else if (advance) begin
      ctl_s1_r <= dec_ctl;
      ctl_s2_r <= ctl_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr_s1_r <= addr;
      a_re_s1_r <= comp_re;
      a_im_s1_r <= comp_im;
      a_re_s2_r <= a_re_s1_r;
      a_im_s2_r <= a_im_s1_r;
    end
  end

  assign ram_wr_en = advance && ctl_s1_r.valid && (ctl_s1_r.cmd == CMD_LOAD);
  assign ram_rd_en = advance && ctl_s1_r.valid && (ctl_s1_r.cmd == CMD_NONZERO);

  csm_ram #(
    .WIDTH(2 * COMP_WIDTH),
    .DEPTH(VEC_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr_s1_r),
    .wr_data ({a_re_s1_r, a_im_s1_r}),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_s1_r),
    .rd_data (ram_rd_data)
  );

  assign ctl_out = ctl_s2_r;
  assign a_re    = a_re_s2_r;
  assign a_im    = a_im_s2_r;
  assign b_re    = $signed(ram_rd_data[2*COMP_WIDTH-1:COMP_WIDTH]);
  assign b_im    = $signed(ram_rd_data[COMP_WIDTH-1:0]);
endmodule
`default_nettype wire

[rtl/csm_cmul.sv]
// Two-stage complex multiplier: partial products, then real and imaginary combine.
`default_nettype none
module csm_cmul import csm_pkg::*; #(
  parameter int COMP_WIDTH = 16,
  localparam int PROD_W = 2 * COMP_WIDTH,
  localparam int PSUM_W = PROD_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  item_ctl_t                    ctl_in,
  input  logic signed [COMP_WIDTH-1:0] a_re,
  input  logic signed [COMP_WIDTH-1:0] a_im,
  input  logic signed [COMP_WIDTH-1:0] b_re,
  input  logic signed [COMP_WIDTH-1:0] b_im,
  output item_ctl_t                    ctl_out,
  output logic signed [PSUM_W-1:0]     p_re,
  output logic signed [PSUM_W-1:0]     p_im
);
  item_ctl_t                 ctl_m_r;
  item_ctl_t                 ctl_p_r;
  logic signed [PROD_W-1:0]  prod_rr_r;
  logic signed [PROD_W-1:0]  prod_ii_r;
  logic signed [PROD_W-1:0]  prod_ri_r;
  logic signed [PROD_W-1:0]  prod_ir_r;
  logic signed [PSUM_W-1:0]  p_re_r;
  logic signed [PSUM_W-1:0]  p_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
      ctl_p_r <= '0;
    end else if (advance) begin
      ctl_m_r <= ctl_in;
      ctl_p_r <= ctl_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_rr_r <= PROD_W'(a_re) * PROD_W'(b_re);
      prod_ii_r <= PROD_W'(a_im) * PROD_W'(b_im);
      prod_ri_r <= PROD_W'(a_re) * PROD_W'(b_im);
      prod_ir_r <= PROD_W'(a_im) * PROD_W'(b_re);
      p_re_r    <= PSUM_W'(prod_rr_r) - PSUM_W'(prod_ii_r);
      p_im_r    <= PSUM_W'(prod_ri_r) + PSUM_W'(prod_ir_r);
    end
  end

  assign ctl_out = ctl_p_r;
  assign p_re    = p_re_r;
  assign p_im    = p_im_r;
endmodule
`default_nettype wire

[rtl/csm_acc.sv]
// Saturating row accumulator, row counter and result register.
`default_nettype none
module csm_acc import csm_pkg::*; #(
  parameter int PSUM_W = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  item_ctl_t                ctl_in,
  input  logic signed [PSUM_W-1:0] p_re,
  input  logic signed [PSUM_W-1:0] p_im,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [ROW_W-1:0]         out_row,
  output logic signed [ACC_W-1:0]  out_sum_re,
  output logic signed [ACC_W-1:0]  out_sum_im
);
  localparam int SUM_W = ((PSUM_W > ACC_W) ? PSUM_W : ACC_W) + 1;

  logic signed [ACC_W-1:0] acc_re_r,     acc_re_nxt;
  logic signed [ACC_W-1:0] acc_im_r,     acc_im_nxt;
  logic [ROW_W-1:0]        row_r,        row_nxt;
  logic                    out_valid_r,  out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r,    out_row_nxt;
  logic signed [ACC_W-1:0] out_sum_re_r, out_sum_re_nxt;
  logic signed [ACC_W-1:0] out_sum_im_r, out_sum_im_nxt;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic in_range;
    in_range = (v[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){v[SUM_W-1]}});
    if (in_range) begin
      return v[ACC_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  assign sum_re = SUM_W'(acc_re_r) + SUM_W'(p_re);
  assign sum_im = SUM_W'(acc_im_r) + SUM_W'(p_im);

  always_comb begin
    acc_re_nxt     = acc_re_r;
    acc_im_nxt     = acc_im_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_row_nxt    = out_row_r;
    out_sum_re_nxt = out_sum_re_r;
    out_sum_im_nxt = out_sum_im_r;
    if (advance && ctl_in.valid) begin
      case (ctl_in.cmd)
        CMD_NONZERO: begin
          acc_re_nxt = sat_acc(sum_re);
          acc_im_nxt = sat_acc(sum_im);
        end
        CMD_END_ROW: begin
          out_valid_nxt  = 1'b1;
          out_row_nxt    = row_r;
          out_sum_re_nxt = acc_re_r;
          out_sum_im_nxt = acc_im_r;
          acc_re_nxt     = '0;
          acc_im_nxt     = '0;
          row_nxt        = row_r + ROW_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_re_r    <= acc_re_nxt;
      acc_im_r    <= acc_im_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r    <= out_row_nxt;
    out_sum_re_r <= out_sum_re_nxt;
    out_sum_im_r <= out_sum_im_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_sum_re = out_sum_re_r;
  assign out_sum_im = out_sum_im_r;
endmodule
`default_nettype wire

[rtl/csr_sparse_matvec.sv]
// Top level of the streaming complex CSR sparse matrix times dense vector block.
//
// Usage: one input word carries a command, an index and a complex Q4.12 value.
// A load word writes the value into the vector store at the index. A nonzero
// word multiplies its value by the stored entry at its column and adds the
// product into the Q24.24 row accumulator, saturating at 48 bits. An end-of-row
// word emits the row number and the row sum on the out_ channel, then clears
// the accumulator and advances the row counter. Command code 3 is dropped.
// Load an entry before any nonzero reads it.
// Throughput: one input word per cycle while in_stall is low, set by the single
// multiply-accumulate per cycle in the accumulator stage.
// Result path: the input register takes an end-of-row word, which then passes
// the vector RAM read, products and combine registers before the result
// register presents its result word.
// Reset clears the pipeline, the accumulators and the row counter; the vector
// store keeps its contents and must be reloaded.
// Stall: the result register holds a finished row while out_stall is high;
// loads and nonzeros keep flowing, and in_stall rises only when the next
// end-of-row word reaches the accumulator while the result is still held.
`default_nettype none
`include "csr_sparse_matvec_defines.svh"
module csr_sparse_matvec import csm_pkg::*; #(
  parameter int VEC_DEPTH  = 1024,
  parameter int COMP_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [IDX_W-1:0]          in_index,
  input  logic signed [FIELD_W-1:0] in_value_re,
  input  logic signed [FIELD_W-1:0] in_value_im,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ROW_W-1:0]          out_row,
  output logic signed [ACC_W-1:0]   out_sum_re,
  output logic signed [ACC_W-1:0]   out_sum_im
);
  localparam int PSUM_W = 2 * COMP_WIDTH + 1;

  item_ctl_t                    ctl_mul;
  item_ctl_t                    ctl_acc;
  logic signed [COMP_WIDTH-1:0] a_re;
  logic signed [COMP_WIDTH-1:0] a_im;
  logic signed [COMP_WIDTH-1:0] b_re;
  logic signed [COMP_WIDTH-1:0] b_im;
  logic signed [PSUM_W-1:0]     p_re;
  logic signed [PSUM_W-1:0]     p_im;
  logic                         hold;
  logic                         advance;
  logic                         eor_adv;

  // freeze the whole pipe only when a new row result would overwrite a held one
  assign hold     = out_valid && out_stall && ctl_acc.valid && (ctl_acc.cmd == CMD_END_ROW);
  assign advance  = !hold;
  assign in_stall = hold;
  assign eor_adv  = advance && ctl_acc.valid && (ctl_acc.cmd == CMD_END_ROW);

  csm_front #(
    .VEC_DEPTH  (VEC_DEPTH),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .in_valid    (in_valid),
    .in_command  (in_command),
    .in_index    (in_index),
    .in_value_re (in_value_re),
    .in_value_im (in_value_im),
    .ctl_out     (ctl_mul),
    .a_re        (a_re),
    .a_im        (a_im),
    .b_re        (b_re),
    .b_im        (b_im)
  );

  csm_cmul #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_cmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctl_in  (ctl_mul),
    .a_re    (a_re),
    .a_im    (a_im),
    .b_re    (b_re),
    .b_im    (b_im),
    .ctl_out (ctl_acc),
    .p_re    (p_re),
    .p_im    (p_im)
  );

  csm_acc #(
    .PSUM_W (PSUM_W)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .ctl_in     (ctl_acc),
    .p_re       (p_re),
    .p_im       (p_im),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_sum_re (out_sum_re),
    .out_sum_im (out_sum_im)
  );

  `CSM_ASSERT_IMPLY(a_stall_only_on_held_result, clk, rst_n, in_stall, out_valid && out_stall)
  `CSM_ASSERT_NEXT(a_end_row_gives_result, clk, rst_n, eor_adv, out_valid)
  `CSM_ASSERT_NEXT(a_no_invented_result, clk, rst_n, out_valid && !out_stall && !eor_adv, !out_valid)
endmodule
`default_nettype wire

[tb/csr_sparse_matvec_checker.sv]
`timescale 1ns / 100ps
// Row-sum predictor and result-word checker for the sparse matrix-vector block.
module csr_sparse_matvec_checker import csm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [IDX_W-1:0]          in_index,
  input  logic signed [FIELD_W-1:0] in_value_re,
  input  logic signed [FIELD_W-1:0] in_value_im,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ROW_W-1:0]          out_row,
  input  logic signed [ACC_W-1:0]   out_sum_re,
  input  logic signed [ACC_W-1:0]   out_sum_im,
  output int                        mismatches,
  output int                        rows_pending
);

  localparam int    VEC_DEPTH = 1024;
  localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -ACC_HI - 1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] re;
    logic [ACC_W-1:0] im;
  } row_sum_t;

  logic signed [FIELD_W-1:0] vec_re [VEC_DEPTH];
  logic signed [FIELD_W-1:0] vec_im [VEC_DEPTH];
  logic signed [ACC_W-1:0]   row_acc_re;
  logic signed [ACC_W-1:0]   row_acc_im;
  logic [ROW_W-1:0]          row_num;
  row_sum_t                  row_sums_due [$];
  row_sum_t                  want;
  longint                    prod_re;
  longint                    prod_im;
  int                        col;

  initial begin
    mismatches   = 0;
    rows_pending = 0;
  end

  function automatic logic signed [ACC_W-1:0] clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_W'(ACC_HI);
    if (v < ACC_LO) return ACC_W'(ACC_LO);
    return ACC_W'(v);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_acc_re = '0;
      row_acc_im = '0;
      row_num    = '0;
      row_sums_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (row_sums_due.size() == 0) begin
          mismatches++;
          $error("unexpected result word: row %0d", out_row);
        end else begin
          want = row_sums_due.pop_front();
          if (out_row !== want.row) begin
            mismatches++;
            $error("row: expected %0d, got %0d", want.row, out_row);
          end
          if (out_sum_re !== want.re) begin
            mismatches++;
            $error("sum_re: expected %0d, got %0d", $signed(want.re), out_sum_re);
          end
          if (out_sum_im !== want.im) begin
            mismatches++;
            $error("sum_im: expected %0d, got %0d", $signed(want.im), out_sum_im);
          end
        end
      end
      if (in_valid && !in_stall) begin
        col = int'(in_index) % VEC_DEPTH;
        case (in_command)
          CMD_LOAD: begin
            vec_re[col] = in_value_re;
            vec_im[col] = in_value_im;
          end
          CMD_NONZERO: begin
            prod_re = longint'(in_value_re) * longint'(vec_re[col])
                    - longint'(in_value_im) * longint'(vec_im[col]);
            prod_im = longint'(in_value_re) * longint'(vec_im[col])
                    + longint'(in_value_im) * longint'(vec_re[col]);
            // clamp after every nonzero, not only at the end of the row
            row_acc_re = clamp_acc(longint'(row_acc_re) + prod_re);
            row_acc_im = clamp_acc(longint'(row_acc_im) + prod_im);
          end
          CMD_END_ROW: begin
            row_sums_due.push_back('{row: row_num, re: row_acc_re, im: row_acc_im});
            row_acc_re = '0;
            row_acc_im = '0;
            row_num    = row_num + 1'b1;
          end
          default: ;  // unused code: drop the word
        endcase
      end
    end
    rows_pending = row_sums_due.size();
  end

endmodule

[tb/tb_csr_sparse_matvec.sv]
`timescale 1ns / 100ps
// Testbench top for the sparse matrix-vector block: stimulus, back-pressure and verdict.
module tb_csr_sparse_matvec;
  import csm_pkg::*;

  localparam logic [CMD_W-1:0]          CMD_UNUSED = 2'd3;
  localparam logic signed [FIELD_W-1:0] COMP_MIN   = 16'sh8000;
  localparam logic signed [FIELD_W-1:0] COMP_MAX   = 16'sh7fff;
  localparam logic [IDX_W-1:0]          SAT_COL    = 10'd1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = '0;
  logic [IDX_W-1:0]          in_index = '0;
  logic signed [FIELD_W-1:0] in_value_re = '0;
  logic signed [FIELD_W-1:0] in_value_im = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ROW_W-1:0]          out_row;
  logic signed [ACC_W-1:0]   out_sum_re;
  logic signed [ACC_W-1:0]   out_sum_im;

  int mismatches;
  int rows_pending;
  int idle_pct = 0;
  int stall_pct = 0;
  bit quiet_row = 1'b0;
  int words_sent = 0;
  int rows_sent = 0;
  bit loaded_map [1024];
  logic [IDX_W-1:0] loaded_cols [$];

  always #5 clk = ~clk;

  csr_sparse_matvec u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_index    (in_index),
    .in_value_re (in_value_re),
    .in_value_im (in_value_im),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_sum_re  (out_sum_re),
    .out_sum_im  (out_sum_im)
  );

  csr_sparse_matvec_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_index     (in_index),
    .in_value_re  (in_value_re),
    .in_value_im  (in_value_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_sum_re   (out_sum_re),
    .out_sum_im   (out_sum_im),
    .mismatches   (mismatches),
    .rows_pending (rows_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic signed [FIELD_W-1:0] pick_comp();
    case ($urandom_range(7))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return FIELD_W'($urandom_range(16)) - FIELD_W'(8);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [FIELD_W-1:0] re,
                           input logic signed [FIELD_W-1:0] im);
    while (!quiet_row && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_index    <= idx;
    in_value_re <= re;
    in_value_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_UNUSED) words_sent++;
    if (cmd == CMD_END_ROW) rows_sent++;
    if (cmd == CMD_LOAD && !loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  // Rows of random length over loaded columns, with loads and unused words mixed in.
  task automatic run_phase(input int idle, input int stall, input int words);
    int start;
    int nnz;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    repeat (16) send_word(CMD_LOAD, IDX_W'($urandom), pick_comp(), pick_comp());
    while (words_sent - start < words) begin
      quiet_row = ($urandom_range(4) == 0);
      nnz = ($urandom_range(7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 6);
      repeat (nnz) begin
        if ($urandom_range(9) == 0)
          send_word(CMD_LOAD, IDX_W'($urandom), pick_comp(), pick_comp());
        if ($urandom_range(19) == 0)
          send_word(CMD_UNUSED, IDX_W'($urandom), pick_comp(), pick_comp());
        send_word(CMD_NONZERO, loaded_cols[$urandom_range(loaded_cols.size() - 1)],
                  pick_comp(), pick_comp());
      end
      send_word(CMD_END_ROW, IDX_W'($urandom), pick_comp(), pick_comp());
    end
    quiet_row = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty row first, then an unused code
    send_word(CMD_END_ROW, '0, '0, '0);
    send_word(CMD_UNUSED, 10'h3ff, COMP_MIN, COMP_MAX);
    send_word(CMD_LOAD, 10'd0, COMP_MIN, COMP_MIN);
    send_word(CMD_LOAD, 10'h3ff, COMP_MAX, COMP_MAX);
    send_word(CMD_LOAD, 10'h2aa, 16'sh5555, 16'shaaaa);
    send_word(CMD_LOAD, 10'h155, 16'shaaaa, 16'sh5555);
    send_word(CMD_LOAD, SAT_COL, COMP_MIN, '0);
    send_word(CMD_LOAD, 10'd2, 16'sh0001, 16'shffff);
    send_word(CMD_NONZERO, 10'd0, COMP_MIN, COMP_MIN);
    send_word(CMD_NONZERO, 10'h3ff, COMP_MAX, COMP_MAX);
    send_word(CMD_NONZERO, 10'h2aa, 16'shffff, '0);
    send_word(CMD_END_ROW, '0, '0, '0);
    send_word(CMD_NONZERO, 10'h155, COMP_MAX, COMP_MIN);
    send_word(CMD_NONZERO, 10'd2, '0, '0);
    send_word(CMD_UNUSED, 10'd2, COMP_MAX, COMP_MAX);
    send_word(CMD_END_ROW, 10'h3ff, COMP_MIN, COMP_MAX);
    // back-to-back empty rows
    send_word(CMD_END_ROW, '0, '0, '0);
    send_word(CMD_END_ROW, '0, '0, '0);
    send_word(CMD_LOAD, 10'd2, COMP_MAX, COMP_MIN);
    send_word(CMD_NONZERO, 10'd2, 16'sh1000, 16'sh1000);
    send_word(CMD_NONZERO, SAT_COL, COMP_MIN, COMP_MIN);
    send_word(CMD_END_ROW, '0, '0, '0);

    run_phase(0, 0, 262);
    run_phase(84, 0, 262);
    run_phase(0, 84, 262);
    run_phase(35, 35, 264);

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    stall_pct = 0;
    repeat (16) @(posedge clk);

    $display("covered %0d input words and %0d rows over %0d loaded columns,",
             words_sent, rows_sent, loaded_cols.size());
    $display("with extreme components, empty rows and four sender/receiver idle mixes");
    if (mismatches == 0) begin
      $display("[csr_sparse_matvec] OK");
    end else begin
      $display("[csr_sparse_matvec] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[csr_sparse_matvec] ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/csm_pkg.sv
rtl/csm_ram.sv
rtl/csm_front.sv
rtl/csm_cmul.sv
rtl/csm_acc.sv
rtl/csr_sparse_matvec.sv
tb/csr_sparse_matvec_checker.sv
tb/tb_csr_sparse_matvec.sv
